// File: sv/ssca_pkg.sv
package ssca_pkg;

  localparam int PageCount = 64;
  localparam int PageBytes = 4096;
  localparam int DataBytes = 4072;
  localparam int MaxReq = 64;
  localparam int LinkUnits = DataBytes / 8;
  localparam int PageW = $clog2(PageCount);
  localparam int LinkW = PageW + 1;
  localparam int OffW = $clog2(PageBytes);
  localparam int OffLW = OffW + 1;
  localparam int AddrW = 18;
  localparam int SlotDepth = PageCount * LinkUnits;
  localparam int SlotW = $clog2(SlotDepth);
  localparam int QDepth = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_PAGE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic cmd;
    logic bad;
    logic [1:0] cls;
    logic [PageW-1:0] page;
    logic [OffW-1:0] off;
  } req_t;

  function automatic logic [1:0] class_of(input logic [6:0] size);
    logic [6:0] v;
    begin
      v = (size - 7'd1) >> 2;
      if (v[3]) class_of = 2'd3;
      else if (v[2]) class_of = 2'd2;
      else if (v[1]) class_of = 2'd1;
      else class_of = 2'd0;
    end
  endfunction

endpackage

// File: sv/ssca_front.sv
module ssca_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic cmd,
  input  logic [6:0] req_size,
  input  logic [ssca_pkg::AddrW-1:0] free_address,
  output logic q_valid,
  input  logic q_pop,
  output ssca_pkg::req_t q_data
);

  ssca_pkg::req_t mem [ssca_pkg::QDepth];
  logic wp, rp;
  logic [1:0] cnt;
  ssca_pkg::req_t cur;
  logic push;

  // every 6-bit page field names a real page, so only the size can be out of range here
  always_comb begin
    cur.cmd = cmd;
    cur.bad = (cmd == ssca_pkg::CMD_ALLOC) &&
              (req_size == 7'd0 || req_size > 7'(ssca_pkg::MaxReq));
    cur.cls = ssca_pkg::class_of(req_size);
    cur.page = free_address[ssca_pkg::OffW +: ssca_pkg::PageW];
    cur.off = free_address[ssca_pkg::OffW-1:0];
  end

  assign in_stall = (cnt == 2'(ssca_pkg::QDepth));
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt != 2'd0);
  assign q_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= cur;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// File: sv/ssca_back.sv
module ssca_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  ssca_pkg::req_t q_data,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [ssca_pkg::AddrW-1:0] slot_address,
  output logic [1:0] size_class
);

  localparam int PW = ssca_pkg::PageW;
  localparam int LW = ssca_pkg::LinkW;
  localparam int OW = ssca_pkg::OffW;
  localparam int OLW = ssca_pkg::OffLW;
  localparam int SW = ssca_pkg::SlotW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_READ  = 5'b00100,
    S_EXEC  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  ssca_pkg::req_t rq;

  logic [LW-1:0] class_head [4];
  logic [LW-1:0] page_next [ssca_pkg::PageCount];
  logic [LW-1:0] page_prev [ssca_pkg::PageCount];
  logic [OLW-1:0] page_ff [ssca_pkg::PageCount];
  logic [1:0] page_cls [ssca_pkg::PageCount];
  logic [OLW-1:0] page_hw [ssca_pkg::PageCount];
  logic [OW-1:0] slot_link [ssca_pkg::SlotDepth];
  logic [LW-1:0] pages_used;

  // resolved page for this op, latched in READ
  logic [PW-1:0] pg;
  logic [1:0] cls;
  logic [OW-1:0] off;
  logic fresh;
  logic [OW-1:0] link_rd;
  logic [SW-1:0] link_addr;

  // page table words, read in FETCH
  logic [PW-1:0] pa;
  logic [OLW-1:0] ff_r, hw_r;
  logic [1:0] cls_r;
  logic [LW-1:0] nx_r, pv_r;

  logic empty_list;
  logic [PW-1:0] alloc_page;
  logic [OW-1:0] off_al;

  assign empty_list = (class_head[rq.cls] == '0);
  assign alloc_page = empty_list ? pages_used[PW-1:0] :
                      PW'(class_head[rq.cls] - LW'(1));
  assign pa = (rq.cmd == ssca_pkg::CMD_ALLOC) ? alloc_page : rq.page;

  always_comb begin
    unique case (cls_r)
      2'd0: off_al = {rq.off[OW-1:3], 3'b0};
      2'd1: off_al = {rq.off[OW-1:4], 4'b0};
      2'd2: off_al = {rq.off[OW-1:5], 5'b0};
      default: off_al = {rq.off[OW-1:6], 6'b0};
    endcase
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // a page opened in READ has not been seen by FETCH
  logic [OLW-1:0] item, nf, hw_e;
  logic [LW-1:0] nx, pv, old;
  assign item = OLW'(8) << cls;
  assign hw_e = fresh ? '0 : hw_r;
  assign nx = fresh ? '0 : nx_r;
  assign pv = fresh ? '0 : pv_r;
  assign old = class_head[cls];
  assign nf = (OLW'(off) >= hw_e) ? OLW'(off) + item : OLW'(link_rd);

  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      ff_r <= page_ff[pa];
      hw_r <= page_hw[pa];
      cls_r <= page_cls[pa];
      nx_r <= page_next[pa];
      pv_r <= page_prev[pa];
    end
    if (state == S_READ) begin
      link_rd <= slot_link[link_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pages_used <= '0;
      for (int i = 0; i < 4; i++) class_head[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            rq <= q_data;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_READ;
        end
        S_READ: begin
          if (rq.cmd == ssca_pkg::CMD_ALLOC) begin
            cls <= rq.cls;
            if (rq.bad) begin
              status <= ssca_pkg::ST_RANGE;
              slot_address <= '0;
              size_class <= 2'd0;
              state <= S_OUT;
            end else if (empty_list && pages_used == LW'(ssca_pkg::PageCount)) begin
              status <= ssca_pkg::ST_NO_PAGE;
              slot_address <= '0;
              size_class <= rq.cls;
              state <= S_OUT;
            end else begin
              state <= S_EXEC;
              pg <= alloc_page;
              fresh <= empty_list;
              off <= empty_list ? '0 : ff_r[OW-1:0];
              if (empty_list) begin
                page_next[alloc_page] <= '0;
                page_prev[alloc_page] <= '0;
                page_ff[alloc_page] <= '0;
                page_hw[alloc_page] <= '0;
                page_cls[alloc_page] <= rq.cls;
                class_head[rq.cls] <= LW'(alloc_page) + LW'(1);
                pages_used <= pages_used + LW'(1);
              end
            end
          end else begin
            cls <= cls_r;
            pg <= rq.page;
            off <= off_al;
            fresh <= 1'b0;
            if (rq.bad || LW'(rq.page) >= pages_used ||
                OLW'(rq.off) >= OLW'(ssca_pkg::DataBytes) ||
                OLW'(off_al) >= hw_r) begin
              status <= ssca_pkg::ST_RANGE;
              slot_address <= '0;
              size_class <= 2'd0;
              state <= S_OUT;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          status <= ssca_pkg::ST_OK;
          slot_address <= {pg, off};
          size_class <= cls;
          state <= S_OUT;
          if (rq.cmd == ssca_pkg::CMD_ALLOC) begin
            if (OLW'(off) >= hw_e) page_hw[pg] <= nf;
            page_ff[pg] <= nf;
            if (nf + item > OLW'(ssca_pkg::DataBytes)) begin
              if (class_head[cls] == LW'(pg) + LW'(1)) class_head[cls] <= nx;
              if (nx != '0) page_prev[PW'(nx - LW'(1))] <= pv;
              if (pv != '0) page_next[PW'(pv - LW'(1))] <= nx;
              page_next[pg] <= '0;
              page_prev[pg] <= '0;
            end
          end else begin
            if (ff_r + item > OLW'(ssca_pkg::DataBytes)) begin
              page_next[pg] <= old;
              page_prev[pg] <= '0;
              if (old != '0) page_prev[PW'(old - LW'(1))] <= LW'(pg) + LW'(1);
              class_head[cls] <= LW'(pg) + LW'(1);
            end
            page_ff[pg] <= OLW'(off);
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // slot link write: free pushes the old first-free offset
  logic [SW-1:0] wr_addr;
  logic [OW-1:0] wr_page_unit;
  assign wr_page_unit = off >> 3;
  assign wr_addr = SW'(pg) * SW'(ssca_pkg::LinkUnits) + SW'(wr_page_unit);

  always_ff @(posedge clk) begin
    if (!rst && state == S_EXEC && rq.cmd == ssca_pkg::CMD_FREE)
      slot_link[wr_addr] <= ff_r[OW-1:0];
  end

  // read index for alloc: head page's first free offset
  logic [OW-1:0] rd_off;
  logic [OW-1:0] rd_unit;
  assign rd_off = ff_r[OW-1:0];
  assign rd_unit = rd_off >> 3;
  assign link_addr = SW'(alloc_page) * SW'(ssca_pkg::LinkUnits) + SW'(rd_unit);

endmodule

// File: sv/slab_size_class_allocator.sv
// Four-class slab allocator (8/16/32/64-byte slots) over 64 pages of 4096 bytes.
// A front queue takes and classifies requests; a back sequencer runs one at a
// time: dispatch, page table read, link read, update, result register and
// hand-off; a rejected request skips the update. The steps follow from the
// dependent registered reads and writes of the page tables and the slot link
// memory. One result per request; the sequencer holds while a result waits,
// and the two-entry queue keeps accepting until it is full.
module slab_size_class_allocator (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic cmd,
  input  logic [6:0] req_size,
  input  logic [17:0] free_address,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [17:0] slot_address,
  output logic [1:0] size_class
);

  logic q_valid, q_pop;
  ssca_pkg::req_t q_data;

  ssca_front u_front (
    .clk, .rst, .in_valid, .in_stall, .cmd, .req_size, .free_address,
    .q_valid, .q_pop, .q_data
  );

  ssca_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .status, .slot_address, .size_class
  );

endmodule
